### rtl/mspt_pkg.sv
// Package for the memory sweep pattern tester.
// Holds opcodes, register indexes, the configuration struct and the LFSR step function.
// No dependencies.
`default_nettype none

package mspt_pkg;

  localparam int unsigned StepsPerWord     = 16;
  localparam logic [31:0] FeedbackMask     = 32'h8101_0040;
  localparam logic [4:0]  MaxBlockLog2     = 5'd20;
  localparam int unsigned PosW             = 20;
  localparam int unsigned ErrCountW        = 24;
  localparam int unsigned CountBitsDefault = 24;
  localparam int unsigned CfgIdxW          = 3;

  localparam logic [31:0] SeedRst        = 32'h0000_babe;
  localparam logic [31:0] BaseAddressRst = 32'h0800_0000;
  localparam logic [4:0]  BlockLog2Rst   = 5'd15;
  localparam logic [4:0]  JumpLog2Rst    = 5'd17;
  localparam logic [4:0]  SpanLog2Rst    = 5'd24;
  localparam logic [15:0] ReportLimitRst = 16'd100;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_WRITE   = 2'd1,
    OP_CHECK   = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEED         = 3'd0,
    REG_BASE_ADDRESS = 3'd1,
    REG_BLOCK_LOG2   = 3'd2,
    REG_JUMP_LOG2    = 3'd3,
    REG_SPAN_LOG2    = 3'd4,
    REG_REPORT_LIMIT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] seed;
    logic [31:0] base_address;
    logic [4:0]  block_log2;
    logic [4:0]  jump_log2;
    logic [4:0]  span_log2;
    logic [15:0] report_limit;
  } cfg_t;

  // Right-shifting Galois LFSR, taps 32/25/17/7, several shifts per word.
  function automatic logic [31:0] lfsr_advance(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int k = 0; k < StepsPerWord; k++) begin
      r = (r >> 1) ^ (r[0] ? FeedbackMask : 32'h0);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mspt_if.sv
// Channel interfaces of the memory sweep pattern tester: command in, result out.
// Stand-alone; no package needed.
`default_nettype none

interface mspt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] read_data;

  modport source (output valid, output opcode, output read_data, input ready);
  modport sink   (input valid, input opcode, input read_data, output ready);
endinterface

interface mspt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic [31:0] pattern;
  logic        mismatch;
  logic        report;
  logic [23:0] error_count;
  logic        sweep_done;

  modport source (output valid, output address, output pattern, output mismatch,
                  output report, output error_count, output sweep_done, input ready);
  modport sink   (input valid, input address, input pattern, input mismatch,
                  input report, input error_count, input sweep_done, output ready);
endinterface

`default_nettype wire

### rtl/memory_sweep_pattern_tester.sv
// Memory sweep pattern tester, top level.
//
// Commands arrive on in_i (opcode, read_data): restart reseeds the LFSR from
// the seed register and rewinds the address sweep; a write step returns the
// next address and pattern; a check step does the same and compares read_data
// against the pattern, counting mismatches (saturating) and flagging those
// that fall under report_limit. Every command yields exactly one transaction
// on out_o. Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the
// user must do so only while no command is in flight; the block does not enforce it.
//
// A command accepted at one edge shows its result at the output register
// from the next cycle. Throughput is one command per cycle while out_o takes
// results; the 16 LFSR shifts, the address add and the wrap compare all sit
// between the input handshake and the output register.
// When out_o stalls, in_i.ready drops only while the output register holds
// an untaken result that is not being taken in the same cycle.
// Reset loads the register defaults, sets the LFSR to one, clears the sweep
// position and the error count, and empties the output register.
// Depends on mspt_pkg, mspt_if and mspt_cfg_regs.
`default_nettype none

module memory_sweep_pattern_tester #(
  parameter int unsigned COUNT_BITS = mspt_pkg::CountBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  mspt_in_if.sink                           in_i,
  mspt_out_if.source                        out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [mspt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                  cfg_wdata_i
);
  import mspt_pkg::*;

  cfg_t cfg;

  mspt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sweep state
  logic [31:0]           lfsr_q, lfsr_d;
  logic [4:0]            exp_q, exp_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic                  finished_q, finished_d;

  // Output register
  logic                  out_valid_q;
  logic [31:0]           addr_q, addr_d;
  logic [31:0]           pat_q, pat_d;
  logic                  mis_q, mis_d;
  logic                  rep_q, rep_d;
  logic [ErrCountW-1:0]  err_q, err_d;
  logic                  done_q, done_d;

  logic                  in_ready;
  logic                  in_accept;
  opcode_e               op;
  logic [31:0]           pat_next;
  logic [4:0]            blk_sat;
  logic [PosW:0]         pos_inc;
  logic [PosW:0]         blk_limit;
  logic                  block_end;
  logic [4:0]            exp_adv;
  logic [29:0]           word_off;
  logic                  is_mis;
  logic [31:0]           total_ext;

  assign in_ready  = !out_valid_q || out_o.ready;
  assign in_accept = in_i.valid && in_ready;
  assign op        = opcode_e'(in_i.opcode);

  assign pat_next  = lfsr_advance(lfsr_q);
  assign blk_sat   = (cfg.block_log2 > MaxBlockLog2) ? MaxBlockLog2 : cfg.block_log2;
  assign pos_inc   = {1'b0, pos_q} + (PosW+1)'(1);
  assign blk_limit = (PosW+1)'(1) << blk_sat;
  assign block_end = pos_inc >= blk_limit;
  // First block sits at offset one; the next jumps straight to 2^jump_log2, or 2^1 if it is zero.
  assign exp_adv   = (exp_q == 5'd0) ? ((cfg.jump_log2 == 5'd0) ? 5'd1 : cfg.jump_log2)
                                     : exp_q + 5'd1;
  // Only the low 30 bits of the word offset reach the 32-bit byte address.
  assign word_off  = (30'(1) << exp_q) + 30'(pos_q);
  assign is_mis    = (op != OP_WRITE) && (in_i.read_data != pat_next);

  always_comb begin
    lfsr_d     = lfsr_q;
    exp_d      = exp_q;
    pos_d      = pos_q;
    total_d    = total_q;
    finished_d = finished_q;
    addr_d     = 32'h0;
    pat_d      = 32'h0;
    mis_d      = 1'b0;
    rep_d      = 1'b0;

    if (op == OP_RESTART) begin
      lfsr_d     = cfg.seed;
      exp_d      = 5'd0;
      pos_d      = '0;
      total_d    = '0;
      finished_d = (cfg.span_log2 == 5'd0);
    end else if (!finished_q) begin
      lfsr_d = pat_next;
      pat_d  = pat_next;
      addr_d = cfg.base_address + {word_off, 2'b00};
      if (is_mis) begin
        mis_d = 1'b1;
        rep_d = 32'(total_q) < 32'(cfg.report_limit);
        if (!(&total_q)) begin
          total_d = total_q + COUNT_BITS'(1);
        end
      end
      if (block_end) begin
        pos_d = '0;
        exp_d = exp_adv;
        if (exp_adv >= cfg.span_log2) begin
          finished_d = 1'b1;
        end
      end else begin
        pos_d = pos_inc[PosW-1:0];
      end
    end

    total_ext = 32'(total_d);
    err_d     = total_ext[ErrCountW-1:0];
    done_d    = finished_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q      <= 32'h1;
      exp_q       <= 5'd0;
      pos_q       <= '0;
      total_q     <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        lfsr_q     <= lfsr_d;
        exp_q      <= exp_d;
        pos_q      <= pos_d;
        total_q    <= total_d;
        finished_q <= finished_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_q <= addr_d;
      pat_q  <= pat_d;
      mis_q  <= mis_d;
      rep_q  <= rep_d;
      err_q  <= err_d;
      done_q <= done_d;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.address     = addr_q;
  assign out_o.pattern     = pat_q;
  assign out_o.mismatch    = mis_q;
  assign out_o.report      = rep_q;
  assign out_o.error_count = err_q;
  assign out_o.sweep_done  = done_q;

  // Every accepted command leaves a result in the output register.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_o.valid)
    else $error("accepted command produced no result");

  // Once the sweep is finished, only a restart can reopen it.
  a_finished_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && finished_q && op != OP_RESTART) |=> finished_q)
    else $error("finished flag cleared without restart");

  // Steps after the sweep return an empty word and flag done.
  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && finished_q && op != OP_RESTART)
      |=> (out_o.pattern == 32'h0 && out_o.address == 32'h0 && out_o.sweep_done))
    else $error("step after sweep end produced a pattern");

  // The mismatch count never drops except on restart.
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && op != OP_RESTART) |=> total_q >= $past(total_q))
    else $error("mismatch count decreased");

  // A reported mismatch is always a mismatch.
  a_report_implies_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.report) |-> out_o.mismatch)
    else $error("report without mismatch");

endmodule

`default_nettype wire

### rtl/mspt_cfg_regs.sv
// Configuration register file of the memory sweep pattern tester.
// Depends on mspt_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module mspt_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mspt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                  cfg_wdata_i,
  output mspt_pkg::cfg_t                    cfg_o
);
  import mspt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SEED:         cfg_d.seed         = cfg_wdata_i;
        REG_BASE_ADDRESS: cfg_d.base_address = cfg_wdata_i;
        REG_BLOCK_LOG2:   cfg_d.block_log2   = cfg_wdata_i[4:0];
        REG_JUMP_LOG2:    cfg_d.jump_log2    = cfg_wdata_i[4:0];
        REG_SPAN_LOG2:    cfg_d.span_log2    = cfg_wdata_i[4:0];
        REG_REPORT_LIMIT: cfg_d.report_limit = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed         <= SeedRst;
      cfg_q.base_address <= BaseAddressRst;
      cfg_q.block_log2   <= BlockLog2Rst;
      cfg_q.jump_log2    <= JumpLog2Rst;
      cfg_q.span_log2    <= SpanLog2Rst;
      cfg_q.report_limit <= ReportLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sim/memory_sweep_pattern_tester_tb.sv
// Self-checking testbench for memory_sweep_pattern_tester: LFSR pattern and address sweep.
// A scoreboard class predicts each result; tasks drive commands and register writes.
// Depends on mspt_pkg, mspt_if and the RTL of the block.

typedef struct packed {
  logic [31:0] address;
  logic [31:0] pattern;
  logic        mismatch;
  logic        report;
  logic [23:0] error_count;
  logic        sweep_done;
} sweep_result_t;

class sweep_scoreboard;
  // register copies
  logic [31:0] seed;
  logic [31:0] base_address;
  logic [4:0]  block_log2;
  logic [4:0]  jump_log2;
  logic [4:0]  span_log2;
  logic [15:0] report_limit;
  // sweep state
  logic [31:0] lfsr;
  logic [4:0]  exponent;
  logic [19:0] position;
  logic [mspt_pkg::CountBitsDefault-1:0] total;
  bit          finished;

  sweep_result_t expected_results[$];
  int unsigned   fail_count;

  function new();
    seed         = mspt_pkg::SeedRst;
    base_address = mspt_pkg::BaseAddressRst;
    block_log2   = mspt_pkg::BlockLog2Rst;
    jump_log2    = mspt_pkg::JumpLog2Rst;
    span_log2    = mspt_pkg::SpanLog2Rst;
    report_limit = mspt_pkg::ReportLimitRst;
    lfsr         = 32'd1;
    exponent     = '0;
    position     = '0;
    total        = '0;
    finished     = 1'b0;
    fail_count   = 0;
  endfunction

  function logic [31:0] advance_word(logic [31:0] v);
    for (int k = 0; k < mspt_pkg::StepsPerWord; k++) begin
      v = {1'b0, v[31:1]} ^ ({32{v[0]}} & mspt_pkg::FeedbackMask);
    end
    return v;
  endfunction

  function logic [31:0] next_pattern();
    return advance_word(lfsr);
  endfunction

  function void set_reg(mspt_pkg::cfg_reg_e idx, logic [31:0] v);
    case (idx)
      mspt_pkg::REG_SEED:         seed = v;
      mspt_pkg::REG_BASE_ADDRESS: base_address = v;
      mspt_pkg::REG_BLOCK_LOG2:   block_log2 = v[4:0];
      mspt_pkg::REG_JUMP_LOG2:    jump_log2 = v[4:0];
      mspt_pkg::REG_SPAN_LOG2:    span_log2 = v[4:0];
      mspt_pkg::REG_REPORT_LIMIT: report_limit = v[15:0];
      default: ;
    endcase
  endfunction

  // Called for every accepted command transaction.
  function void note_command(logic [1:0] op, logic [31:0] rd);
    sweep_result_t want;
    logic [4:0]    blk;
    logic [63:0]   offset;
    want = '0;
    if (op == mspt_pkg::OP_RESTART) begin
      lfsr     = seed;
      exponent = '0;
      position = '0;
      total    = '0;
      finished = (span_log2 == 5'd0);
    end else if (!finished) begin
      blk    = (block_log2 > mspt_pkg::MaxBlockLog2) ? mspt_pkg::MaxBlockLog2 : block_log2;
      offset = (64'd1 << exponent) + 64'(position);
      lfsr   = advance_word(lfsr);
      want.pattern = lfsr;
      want.address = base_address + {offset[29:0], 2'b00};
      // anything but a write step compares read data
      if (op != mspt_pkg::OP_WRITE && rd != lfsr) begin
        want.mismatch = 1'b1;
        want.report   = (total < report_limit);
        if (total != '1) total++;
      end
      position++;
      // wrap of the 20-bit position also ends the block
      if (position == '0 || {1'b0, position} >= (21'd1 << blk)) begin
        position = '0;
        if (exponent == 5'd0) exponent = (jump_log2 == 5'd0) ? 5'd1 : jump_log2;
        else                  exponent = exponent + 5'd1;
        if (exponent >= span_log2) finished = 1'b1;
      end
    end
    want.error_count = total[23:0];
    want.sweep_done  = finished;
    expected_results.push_back(want);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    $display("MISMATCH %s: got %h want %h", what, got, want);
  endtask

  task check_result(sweep_result_t got);
    sweep_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing pending, address", got.address, '0);
      return;
    end
    want = expected_results.pop_front();
    if (got.address !== want.address) report_mismatch("address", got.address, want.address);
    if (got.pattern !== want.pattern) report_mismatch("pattern", got.pattern, want.pattern);
    if (got.mismatch !== want.mismatch)
      report_mismatch("mismatch", 32'(got.mismatch), 32'(want.mismatch));
    if (got.report !== want.report) report_mismatch("report", 32'(got.report), 32'(want.report));
    if (got.error_count !== want.error_count)
      report_mismatch("error_count", 32'(got.error_count), 32'(want.error_count));
    if (got.sweep_done !== want.sweep_done)
      report_mismatch("sweep_done", 32'(got.sweep_done), 32'(want.sweep_done));
  endtask
endclass

module memory_sweep_pattern_tester_tb;
  import mspt_pkg::*;

  localparam logic [1:0]  OpUnused    = 2'd3;  // decodes as a check step
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned IdleCycles  = 4;
  localparam int unsigned PassCap     = 300;
  localparam int unsigned RandomItems = 1500;

  typedef enum { RD_MATCH, RD_FLIP, RD_RANDOM } rd_kind_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [31:0]         cfg_wdata_i;

  mspt_in_if  cmd_if ();
  mspt_out_if res_if ();

  memory_sweep_pattern_tester dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (cmd_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  sweep_scoreboard sb;
  bit              gapless = 1'b0;
  int unsigned     live_items = 0;
  int unsigned     cycle_count = 0;
  int unsigned     sink_run = 0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side back-pressure: alternating runs of ready and stall.
  always @(posedge clk_i) begin : sink_pacing
    int unsigned r;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      sink_run     <= 0;
    end else if (sink_run != 0) begin
      sink_run <= sink_run - 1;
    end else begin
      r = $urandom_range(99);
      if (res_if.ready) begin
        res_if.ready <= 1'b0;
        if (r < 70)      sink_run <= $urandom_range(0, 1);
        else if (r < 95) sink_run <= $urandom_range(2, 7);
        else             sink_run <= $urandom_range(20, 60);
      end else begin
        res_if.ready <= 1'b1;
        if (r < 40)      sink_run <= $urandom_range(0, 3);
        else if (r < 90) sink_run <= $urandom_range(4, 30);
        else             sink_run <= $urandom_range(100, 300);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    sweep_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.address     = res_if.address;
      got.pattern     = res_if.pattern;
      got.mismatch    = res_if.mismatch;
      got.report      = res_if.report;
      got.error_count = res_if.error_count;
      got.sweep_done  = res_if.sweep_done;
      sb.check_result(got);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gapless) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_command(input logic [1:0] op, input logic [31:0] rd);
    int unsigned gap;
    cmd_if.valid     <= 1'b1;
    cmd_if.opcode    <= op;
    cmd_if.read_data <= rd;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    if (op == OP_RESTART || !sb.finished) live_items++;
    sb.note_command(op, rd);
    if ($urandom_range(99) < 2) begin
      drain_results();
    end else begin
      gap = pick_gap();
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_step(input logic [1:0] op, input rd_kind_e kind);
    logic [31:0] rd;
    rd = sb.next_pattern();
    case (kind)
      RD_FLIP:   rd = rd ^ (32'd1 << $urandom_range(31));
      RD_RANDOM: rd = $urandom();
      default: ;
    endcase
    send_command(op, rd);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic program_settings(input logic [31:0] s, input logic [31:0] b,
                                  input logic [4:0] bl, input logic [4:0] jl,
                                  input logic [4:0] sl, input logic [15:0] lim);
    drain_results();
    repeat (IdleCycles) @(posedge clk_i);
    write_reg(REG_SEED, s);
    write_reg(REG_BASE_ADDRESS, b);
    write_reg(REG_BLOCK_LOG2, 32'(bl));
    write_reg(REG_JUMP_LOG2, 32'(jl));
    write_reg(REG_SPAN_LOG2, 32'(sl));
    write_reg(REG_REPORT_LIMIT, 32'(lim));
    cfg_we_i <= 1'b0;
  endtask

  function automatic rd_kind_e pick_rd_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return RD_MATCH;
    if (r < 85) return RD_FLIP;
    return RD_RANDOM;
  endfunction

  // Steps until the sweep ends or PassCap steps are sent, with the odd restart thrown in.
  task automatic sweep_pass(input logic [1:0] op);
    int unsigned steps;
    steps = 0;
    while (!sb.finished && steps < PassCap) begin
      if ($urandom_range(99) < 2) send_step(OP_RESTART, RD_RANDOM);
      else                        send_step(op, pick_rd_kind());
      steps++;
    end
    repeat ($urandom_range(2)) send_step(op, RD_RANDOM);
  endtask

  task automatic run_random_phase();
    logic [31:0] s, b;
    logic [4:0]  bl, jl, sl;
    logic [15:0] lim;
    int unsigned r, n;
    logic [1:0]  op;

    r = $urandom_range(99);
    s = (r < 10) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF : $urandom();
    r = $urandom_range(99);
    b = (r < 20) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom();
    r = $urandom_range(99);
    if (r < 75)      bl = 5'($urandom_range(0, 3));
    else if (r < 92) bl = 5'($urandom_range(4, 5));
    else if (r < 97) bl = 5'd20;
    else             bl = 5'($urandom_range(21, 31));
    r = $urandom_range(99);
    if (r < 10)      jl = 5'd0;
    else if (r < 80) jl = 5'($urandom_range(1, 8));
    else             jl = 5'($urandom_range(9, 31));
    r = $urandom_range(99);
    if (r < 10)      sl = 5'd0;
    else if (r < 70) sl = (jl > 27) ? 5'd31 : jl + 5'($urandom_range(4));
    else             sl = 5'($urandom_range(1, 31));
    r = $urandom_range(99);
    if (r < 25)      lim = 16'd0;
    else if (r < 60) lim = 16'($urandom_range(1, 4));
    else if (r < 75) lim = 16'hFFFF;
    else             lim = 16'($urandom());

    program_settings(s, b, bl, jl, sl, lim);
    gapless = ($urandom_range(3) == 0);

    if ($urandom_range(9) < 7) begin
      // write the region, then read it back; sometimes carry on the old sweep first
      if ($urandom_range(9) != 0) send_step(OP_RESTART, RD_RANDOM);
      sweep_pass(OP_WRITE);
      send_step(OP_RESTART, RD_RANDOM);
      sweep_pass(($urandom_range(4) == 0) ? OpUnused : OP_CHECK);
    end else begin
      n = $urandom_range(20, 80);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 8)       op = OP_RESTART;
        else if (r < 48) op = OP_WRITE;
        else if (r < 88) op = OP_CHECK;
        else             op = OpUnused;
        send_step(op, pick_rd_kind());
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni           <= 1'b0;
    cmd_if.valid     <= 1'b0;
    cmd_if.opcode    <= OP_RESTART;
    cmd_if.read_data <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_SEED;
    cfg_wdata_i      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // straight out of reset: LFSR at one, default registers
    send_step(OP_WRITE, RD_RANDOM);
    send_step(OP_CHECK, RD_MATCH);
    send_step(OP_CHECK, RD_FLIP);
    send_step(OpUnused, RD_RANDOM);

    // one-word blocks, zero jump taken as one, address wraps, single report
    program_settings(32'hFFFF_FFFF, 32'hFFFF_FFF0, 5'd0, 5'd0, 5'd3, 16'd1);
    send_step(OP_RESTART, RD_RANDOM);
    send_step(OP_WRITE, RD_RANDOM);
    send_step(OP_CHECK, RD_FLIP);
    send_step(OpUnused, RD_FLIP);
    send_step(OP_CHECK, RD_FLIP);
    send_step(OP_WRITE, RD_RANDOM);

    // zero span: done right at restart
    program_settings(32'h0, 32'h0, 5'd31, 5'd31, 5'd0, 16'd0);
    send_step(OP_RESTART, RD_RANDOM);
    send_step(OP_WRITE, RD_RANDOM);

    // oversized block clamps to 2^20 words
    program_settings(32'h1234_5678, 32'h0, 5'd31, 5'd31, 5'd31, 16'hFFFF);
    send_step(OP_RESTART, RD_RANDOM);
    send_step(OP_WRITE, RD_RANDOM);
    send_step(OP_CHECK, RD_RANDOM);
    send_step(OP_CHECK, RD_MATCH);

    // jump straight to 2^30 words: offset wraps the byte address
    program_settings($urandom(), 32'h8000_0000, 5'd1, 5'd30, 5'd31, 16'd0);
    send_step(OP_RESTART, RD_RANDOM);
    send_step(OP_CHECK, RD_FLIP);
    send_step(OP_WRITE, RD_RANDOM);
    send_step(OP_CHECK, RD_MATCH);
    send_step(OP_CHECK, RD_RANDOM);
    send_step(OP_CHECK, RD_RANDOM);

    live_items = 0;
    while (live_items < RandomItems) run_random_phase();

    drain_results();
    repeat (IdleCycles) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
